@@ hdl/epoch_seconds_to_calendar_date_assert.svh @@
// Assertion macros for the epoch-to-date converter.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_ASSERT_SVH

// check consequent in the same cycle
`define ECD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// check consequent in the next cycle
`define ECD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ecd_pkg.sv @@
// Shared widths, constants and calendar helpers for the epoch-to-date converter.
// No dependencies.
package ecd_pkg;

  localparam int EpochW  = 32;
  localparam int OffsetW = 17;
  localparam int TotW    = EpochW + 2;
  localparam int YearW   = 12;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinW    = 6;
  localparam int SecW    = 6;
  localparam int RemW    = 17;
  localparam int AluW    = RemW + 1;
  localparam int CntW    = 5;
  localparam int Mod100W = 7;
  localparam int Mod400W = 9;

  localparam logic [OffsetW-1:0] OffsetReset = 17'd28800;

  localparam int SecsPerDay  = 86400;
  localparam int SecsPerHour = 3600;
  localparam int SecsPerMin  = 60;

  localparam logic [YearW-1:0]   EpochYear   = 12'd1970;
  localparam logic [Mod100W-1:0] Mod100Init  = 7'd70;
  localparam logic [Mod100W-1:0] Mod100Last  = 7'd99;
  localparam logic [Mod400W-1:0] Mod400Init  = 9'd370;
  localparam logic [Mod400W-1:0] Mod400Last  = 9'd399;

  localparam logic [AluW-1:0] DaysLeapYear = 18'd366;
  localparam logic [AluW-1:0] DaysYear     = 18'd365;

  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonApr = 4'd4;
  localparam logic [MonthW-1:0] MonJun = 4'd6;
  localparam logic [MonthW-1:0] MonSep = 4'd9;
  localparam logic [MonthW-1:0] MonNov = 4'd11;
  localparam logic [MonthW-1:0] MonDec = 4'd12;

  typedef struct packed {
    logic init;
    logic step;
  } year_ctl_t;

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] mon,
                                                 input logic leap);
    logic [DayW-1:0] len;
    if (mon == MonFeb) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (mon == MonApr || mon == MonJun || mon == MonSep || mon == MonNov) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

@@ hdl/ecd_sub_unit.sv @@
// Shared compare-and-subtract unit: a minus b with a greater-or-equal flag.
// Depends on ecd_pkg.
module ecd_sub_unit (
  input  logic [ecd_pkg::AluW-1:0] a_i,
  input  logic [ecd_pkg::AluW-1:0] b_i,
  output logic                     ge_o,
  output logic [ecd_pkg::AluW-1:0] diff_o
);
  import ecd_pkg::*;

  logic [AluW:0] wide;

  assign wide   = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~wide[AluW];
  assign diff_o = wide[AluW-1:0];

endmodule

@@ hdl/ecd_year_track.sv @@
// Year counter with running mod-100 and mod-400 residues and the leap flag.
// Depends on ecd_pkg.
module ecd_year_track (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ecd_pkg::year_ctl_t         ctl_i,
  output logic [ecd_pkg::YearW-1:0]  year_o,
  output logic                       leap_o
);
  import ecd_pkg::*;

  logic [YearW-1:0]   year_q, year_d;
  logic [Mod100W-1:0] m100_q, m100_d;
  logic [Mod400W-1:0] m400_q, m400_d;

  always_comb begin
    year_d = year_q;
    m100_d = m100_q;
    m400_d = m400_q;
    if (ctl_i.init) begin
      year_d = EpochYear;
      m100_d = Mod100Init;
      m400_d = Mod400Init;
    end else if (ctl_i.step) begin
      year_d = year_q + 1'b1;
      m100_d = (m100_q == Mod100Last) ? '0 : m100_q + 1'b1;
      m400_d = (m400_q == Mod400Last) ? '0 : m400_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q <= EpochYear;
      m100_q <= Mod100Init;
      m400_q <= Mod400Init;
    end else begin
      year_q <= year_d;
      m100_q <= m100_d;
      m400_q <= m400_d;
    end
  end

  assign year_o = year_q;
  assign leap_o = (m400_q == '0) || ((year_q[1:0] == 2'b00) && (m100_q != '0));

endmodule

@@ hdl/epoch_seconds_to_calendar_date.sv @@
// Epoch seconds to local calendar date: sequencer, operand muxing and result registers.
// Depends on ecd_pkg, ecd_sub_unit, ecd_year_track and the assertion macro header.
//
// Usage:
//   Pulse start with epoch_seconds_i while busy is low; the word is taken at
//   that edge. busy stays high until the result has been shown.
//   The result appears for exactly one cycle with result_valid_o high; the
//   receiver cannot stall it and must capture it in that cycle.
//   cfg_we_i writes cfg_wdata_i (signed seconds) into the zone offset;
//   write only while busy is low. Reset sets the offset to +8 hours.
// Steps, accept edge to result:
//   the day division, then hours, then minutes, then the elapsed years one at
//   a time, then the elapsed months one at a time, then the result (years
//   after 1970 up to 136).
//   A negative total skips all steps and goes straight to the result.
// busy drops in the cycle after the result, so a new word is taken only
//   once the last word is through.
// All steps go through one 18-bit compare-and-subtract unit, which sets the rate.
// Reset returns the sequencer to idle with no result pending.
module epoch_seconds_to_calendar_date (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ecd_pkg::EpochW-1:0]    epoch_seconds_i,
  input  logic                          cfg_we_i,
  input  logic [ecd_pkg::OffsetW-1:0]   cfg_wdata_i,
  output logic                          result_valid_o,
  output logic [ecd_pkg::YearW-1:0]     year_o,
  output logic [ecd_pkg::MonthW-1:0]    month_o,
  output logic [ecd_pkg::DayW-1:0]      day_of_month_o,
  output logic [ecd_pkg::HourW-1:0]     hour_o,
  output logic [ecd_pkg::MinW-1:0]      minute_o,
  output logic [ecd_pkg::SecW-1:0]      second_o,
  output logic                          range_error_o
);
  import ecd_pkg::*;

  `include "epoch_seconds_to_calendar_date_assert.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DAY   = 3'd1;
  localparam logic [2:0] S_HOUR  = 3'd2;
  localparam logic [2:0] S_MIN   = 3'd3;
  localparam logic [2:0] S_YEAR  = 3'd4;
  localparam logic [2:0] S_MONTH = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int DayQW = RemW;

  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [RemW-1:0]    quo_q, quo_d;
  logic [RemW-1:0]    days_q, days_d;
  logic [HourW-1:0]   hour_q, hour_d;
  logic [MinW-1:0]    min_q, min_d;
  logic [SecW-1:0]    sec_q, sec_d;
  logic [MonthW-1:0]  month_q, month_d;
  logic               err_q, err_d;
  logic [OffsetW-1:0] offset_q;

  logic [TotW-1:0]    total;
  logic [AluW-1:0]    alu_a, alu_b, alu_diff, trial;
  logic               alu_ge;
  logic [RemW-1:0]    new_rem;
  logic [YearW-1:0]   year_val;
  logic               leap;
  year_ctl_t          yctl;

  assign total = {2'b00, epoch_seconds_i}
               + {{(TotW-OffsetW){offset_q[OffsetW-1]}}, offset_q};
  assign trial = {rem_q, quo_q[RemW-1]};

  always_comb begin
    unique case (state_q)
      S_DAY: begin
        alu_a = trial;
        alu_b = AluW'(SecsPerDay);
      end
      S_HOUR: begin
        alu_a = trial;
        alu_b = AluW'(SecsPerHour);
      end
      S_MIN: begin
        alu_a = trial;
        alu_b = AluW'(SecsPerMin);
      end
      S_YEAR: begin
        alu_a = {1'b0, days_q};
        alu_b = leap ? DaysLeapYear : DaysYear;
      end
      S_MONTH: begin
        alu_a = {1'b0, days_q};
        alu_b = AluW'(month_days(month_q, leap));
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  ecd_sub_unit u_sub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .ge_o  (alu_ge),
    .diff_o(alu_diff)
  );

  ecd_year_track u_year (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (yctl),
    .year_o(year_val),
    .leap_o(leap)
  );

  assign new_rem = alu_ge ? alu_diff[RemW-1:0] : trial[RemW-1:0];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    days_d    = days_q;
    hour_d    = hour_q;
    min_d     = min_q;
    sec_d     = sec_q;
    month_d   = month_q;
    err_d     = err_q;
    yctl.init = 1'b0;
    yctl.step = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (total[TotW-1]) begin
            err_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            err_d     = 1'b0;
            rem_d     = RemW'(total[TotW-2:DayQW]);
            quo_d     = total[DayQW-1:0];
            cnt_d     = CntW'(DayQW - 1);
            month_d   = MonJan;
            yctl.init = 1'b1;
            state_d   = S_DAY;
          end
        end
      end
      S_DAY: begin
        if (cnt_q == '0) begin
          days_d  = {quo_q[RemW-2:0], alu_ge};
          rem_d   = new_rem >> HourW;
          quo_d   = {new_rem[HourW-1:0], {(RemW-HourW){1'b0}}};
          cnt_d   = CntW'(HourW - 1);
          state_d = S_HOUR;
        end else begin
          rem_d = new_rem;
          quo_d = {quo_q[RemW-2:0], alu_ge};
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_HOUR: begin
        if (cnt_q == '0) begin
          hour_d  = {quo_q[HourW-2:0], alu_ge};
          rem_d   = new_rem >> MinW;
          quo_d   = {new_rem[MinW-1:0], {(RemW-MinW){1'b0}}};
          cnt_d   = CntW'(MinW - 1);
          state_d = S_MIN;
        end else begin
          rem_d = new_rem;
          quo_d = {quo_q[RemW-2:0], alu_ge};
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_MIN: begin
        if (cnt_q == '0) begin
          min_d   = {quo_q[MinW-2:0], alu_ge};
          sec_d   = new_rem[SecW-1:0];
          state_d = S_YEAR;
        end else begin
          rem_d = new_rem;
          quo_d = {quo_q[RemW-2:0], alu_ge};
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_YEAR: begin
        if (alu_ge) begin
          days_d    = alu_diff[RemW-1:0];
          yctl.step = 1'b1;
        end else begin
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        if (month_q == MonDec || !alu_ge) begin
          state_d = S_DONE;
        end else begin
          days_d  = alu_diff[RemW-1:0];
          month_d = month_q + 1'b1;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      err_q    <= 1'b0;
      offset_q <= OffsetReset;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    days_q  <= days_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    sec_q   <= sec_d;
    month_q <= month_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);
  assign range_error_o  = err_q;
  assign year_o         = err_q ? '0 : year_val;
  assign month_o        = err_q ? '0 : month_q;
  assign day_of_month_o = err_q ? '0 : days_q[DayW-1:0] + 1'b1;
  assign hour_o         = err_q ? '0 : hour_q;
  assign minute_o       = err_q ? '0 : min_q;
  assign second_o       = err_q ? '0 : sec_q;

  `ECD_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o, "result strobe held over one cycle")
  `ECD_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy not raised after start")
  `ECD_ASSERT_SAME(a_error_zero, result_valid_o && range_error_o, year_o == '0 && month_o == '0 && day_of_month_o == '0 && hour_o == '0 && minute_o == '0 && second_o == '0, "fields not zero on range error")
  `ECD_ASSERT_SAME(a_fields_legal, result_valid_o && !range_error_o, month_o >= MonJan && month_o <= MonDec && day_of_month_o != '0 && hour_o < HourW'(24) && minute_o < MinW'(60) && second_o < SecW'(60), "date or time field out of range")

endmodule

@@ tb/epoch_seconds_to_calendar_date_checker.sv @@
// Checker for the epoch-to-date converter: predicts each accepted word, compares results.
// Depends on ecd_pkg for field widths and the offset reset value.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_date_checker
  import ecd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [EpochW-1:0]   epoch_seconds_i,
  input  logic                cfg_we_i,
  input  logic [OffsetW-1:0]  cfg_wdata_i,
  input  logic                result_valid_i,
  input  logic [YearW-1:0]    year_i,
  input  logic [MonthW-1:0]   month_i,
  input  logic [DayW-1:0]     day_of_month_i,
  input  logic [HourW-1:0]    hour_i,
  input  logic [MinW-1:0]     minute_i,
  input  logic [SecW-1:0]     second_i,
  input  logic                range_error_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
    logic              range_error;
  } date_word_t;

  date_word_t                 due_dates_q[$];
  logic signed [OffsetW-1:0]  zone_offset;
  int                         mismatches;

  function automatic bit leap_year(input int yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic int days_in_month(input int mon, input bit leap);
    unique case (mon)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic date_word_t civil_date(input logic [EpochW-1:0] secs,
                                            input logic signed [OffsetW-1:0] zone);
    date_word_t d;
    longint     total;
    longint     days;
    int         yr;
    int         mon;
    bit         leap;
    d = '0;
    total = longint'(secs) + longint'(zone);
    if (total < 0) begin
      d.range_error = 1'b1;
      return d;
    end
    d.second = SecW'(total % 60);
    d.minute = MinW'((total / 60) % 60);
    d.hour   = HourW'((total / 3600) % 24);
    days = total / 86400;
    yr = 1970;
    while (days >= (leap_year(yr) ? 366 : 365)) begin
      days -= leap_year(yr) ? 366 : 365;
      yr++;
    end
    leap = leap_year(yr);
    mon = 1;
    while (mon < 12 && days >= days_in_month(mon, leap)) begin
      days -= days_in_month(mon, leap);
      mon++;
    end
    d.year  = YearW'(yr);
    d.month = MonthW'(mon);
    d.day   = DayW'(days + 1);
    return d;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 50) begin
      $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic compare_date(input date_word_t got, input date_word_t want);
    if (got.year != want.year) flag_mismatch("year", got.year, want.year);
    if (got.month != want.month) flag_mismatch("month", got.month, want.month);
    if (got.day != want.day) flag_mismatch("day_of_month", got.day, want.day);
    if (got.hour != want.hour) flag_mismatch("hour", got.hour, want.hour);
    if (got.minute != want.minute) flag_mismatch("minute", got.minute, want.minute);
    if (got.second != want.second) flag_mismatch("second", got.second, want.second);
    if (got.range_error != want.range_error) begin
      flag_mismatch("range_error", got.range_error, want.range_error);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    date_word_t got;
    if (!rst_ni) begin
      zone_offset  <= OffsetReset;
      due_dates_q.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (start_i && !busy_i) begin
        due_dates_q.push_back(civil_date(epoch_seconds_i, zone_offset));
      end
      if (result_valid_i) begin
        got = '{year_i, month_i, day_of_month_i, hour_i, minute_i, second_i, range_error_i};
        if (due_dates_q.size() == 0) begin
          flag_mismatch("result strobe with no word pending", 1, 0);
        end else begin
          compare_date(got, due_dates_q.pop_front());
        end
      end
      if (cfg_we_i) begin
        zone_offset <= cfg_wdata_i;
      end
      pending_o    <= due_dates_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

@@ tb/tb_epoch_seconds_to_calendar_date.sv @@
// Testbench top for the epoch-to-date converter: clock, reset, stimulus and verdict.
// Depends on ecd_pkg, the converter RTL and epoch_seconds_to_calendar_date_checker.
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_date;
  import ecd_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 200;
  localparam int PhaseWords  = 75;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [EpochW-1:0]   epoch_seconds_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [OffsetW-1:0]  cfg_wdata_i = '0;
  logic                result_valid_o;
  logic [YearW-1:0]    year_o;
  logic [MonthW-1:0]   month_o;
  logic [DayW-1:0]     day_of_month_o;
  logic [HourW-1:0]    hour_o;
  logic [MinW-1:0]     minute_o;
  logic [SecW-1:0]     second_o;
  logic                range_error_o;

  int  fail_count;
  int  pending;
  int  stall_cycles = 0;
  int  zone_now = 28800;
  bit  idle_on = 1'b0;

  epoch_seconds_to_calendar_date u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .epoch_seconds_i(epoch_seconds_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o),
    .range_error_o  (range_error_o)
  );

  epoch_seconds_to_calendar_date_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .epoch_seconds_i(epoch_seconds_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_i (result_valid_o),
    .year_i         (year_o),
    .month_i        (month_o),
    .day_of_month_i (day_of_month_o),
    .hour_i         (hour_o),
    .minute_i       (minute_o),
    .second_i       (second_o),
    .range_error_i  (range_error_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // wall-clock seconds in the current zone back to a raw epoch word
  function automatic logic [EpochW-1:0] epoch_for(input longint wall_secs);
    return EpochW'(wall_secs - zone_now);
  endfunction

  function automatic logic [EpochW-1:0] pick_epoch();
    longint wall_secs;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 200000);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
      default: begin
        wall_secs = longint'($urandom_range(0, 49710)) * 86400 - $urandom_range(0, 1);
        return epoch_for(wall_secs);
      end
    endcase
  endfunction

  task automatic send_word(input logic [EpochW-1:0] secs);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    start <= 1'b1;
    epoch_seconds_i <= secs;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
  endtask

  task automatic write_offset(input logic [OffsetW-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    zone_now    = int'($signed(value));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [OffsetW-1:0] phase_offsets[10];
    phase_offsets = '{17'd28800, 17'd0, -17'sd50400, 17'd50400, 17'h10000, 17'h0FFFF,
                      17'h1FFFF, 17'h0, 17'h0, 17'h0};
    for (int i = 7; i < 10; i++) phase_offsets[i] = OffsetW'($urandom());

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of the word, then day, month, year and leap boundaries at reset offset
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0000);
    send_word(epoch_for(59));
    send_word(epoch_for(60));
    send_word(epoch_for(3599));
    send_word(epoch_for(86399));
    send_word(epoch_for(86400));
    send_word(epoch_for(31535999));
    send_word(epoch_for(94694399));
    send_word(epoch_for(951782399));
    send_word(epoch_for(951782400));
    send_word(epoch_for(978307199));
    send_word(epoch_for(978307200));
    send_word(epoch_for(4107542399));
    send_word(epoch_for(4107542400));

    // negative totals and the offset extremes
    write_offset(-17'sd50400);
    send_word(32'd0);
    send_word(32'd50399);
    send_word(32'd50400);
    write_offset(17'h10000);
    send_word(32'd65535);
    send_word(32'd65536);
    write_offset(17'h0FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'd0);

    for (int p = 0; p < 10; p++) begin
      write_offset(phase_offsets[p]);
      idle_on = (p != 9) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PhaseWords; n++) begin
        if (p == 4 && n == PhaseWords / 2) wait_drained();
        send_word(pick_epoch());
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ecd_pkg.sv
hdl/ecd_sub_unit.sv
hdl/ecd_year_track.sv
hdl/epoch_seconds_to_calendar_date.sv
tb/epoch_seconds_to_calendar_date_checker.sv
tb/tb_epoch_seconds_to_calendar_date.sv
